// File: hdl/frqs_pkg.sv
`default_nettype none

package frqs_pkg;

    // Fixed field widths of the transaction payloads
    localparam int FUNC_W   = 2;
    localparam int ID_W     = 8;
    localparam int QCOUNT_W = 5;
    localparam int STATUS_W = 2;

    // Defaults for the top-level parameters
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int ID_BITS_DEF     = 8;

    // Operation codes
    localparam logic [FUNC_W-1:0] FN_YIELD = 2'd0;
    localparam logic [FUNC_W-1:0] FN_ADD   = 2'd1;
    localparam logic [FUNC_W-1:0] FN_TERM  = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NONE     = 2'd3;

    // Per-cell command: load has priority over shift
    typedef struct packed {
        logic shift;   // take the right neighbor's entry
        logic load;    // take the broadcast load value
    } cell_cmd_t;

endpackage

`default_nettype wire

// File: hdl/frqs_req_if.sv
`default_nettype none

interface frqs_req_if;
    import frqs_pkg::*;

    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [ID_W-1:0]   thread_id;

    modport source (output valid, output func, output thread_id, input ready);
    modport sink   (input valid, input func, input thread_id, output ready);
endinterface

`default_nettype wire

// File: hdl/frqs_rsp_if.sv
`default_nettype none

interface frqs_rsp_if;
    import frqs_pkg::*;

    logic                valid;
    logic                ready;
    logic                dispatch_valid;
    logic [ID_W-1:0]     dispatch_id;
    logic                running_valid;
    logic [ID_W-1:0]     running_id;
    logic [QCOUNT_W-1:0] queue_count;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output dispatch_valid, output dispatch_id,
                    output running_valid, output running_id, output queue_count,
                    output status, input ready);
    modport sink   (input valid, input dispatch_valid, input dispatch_id,
                    input running_valid, input running_id, input queue_count,
                    input status, output ready);
endinterface

`default_nettype wire

// File: hdl/fifo_ready_queue_scheduler_core.sv
// Round-robin FIFO ready-queue thread scheduler. The ready queue is a row of
// QUEUE_DEPTH cells with the head at cell 0 plus a running-thread register;
// each request transaction (yield, add, terminate) returns exactly one
// result transaction with the dispatch decision, the running thread, the
// queue count (low 5 bits) and a status code. Requests are handled one at a
// time. Yield, add and unused codes pass from acceptance through the execute
// state to the result, waiting there while the result slot is full. Terminate
// rotates the whole queue once through the cell row to find and drop the
// first matching id; if the running thread has that id, the queue head is
// dispatched in its place. The request side is ready again in the same
// cycle that a result appears, even while that result still waits to be
// taken.
`default_nettype none

module fifo_ready_queue_scheduler_core #(
    parameter int QUEUE_DEPTH = frqs_pkg::QUEUE_DEPTH_DEF,
    parameter int ID_BITS     = frqs_pkg::ID_BITS_DEF
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    frqs_req_if.sink    req,
    frqs_rsp_if.source  rsp
);
    import frqs_pkg::*;

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE    = 4'b0001,
        S_EXEC    = 4'b0010,
        S_SCAN    = 4'b0100,
        S_RESOLVE = 4'b1000
    } state_t;

    state_t             state_reg, state_next;
    logic [FUNC_W-1:0]  func_reg, func_next;
    logic [ID_BITS-1:0] id_reg, id_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [CNT_W-1:0]   scan_reg, scan_next;
    logic               found_reg, found_next;
    logic               run_valid_reg, run_valid_next;
    logic [ID_BITS-1:0] run_id_reg, run_id_next;

    // Result register
    logic                rsp_valid_reg;
    logic                o_disp_valid_reg;
    logic [ID_W-1:0]     o_disp_id_reg;
    logic                o_run_valid_reg;
    logic [ID_W-1:0]     o_run_id_reg;
    logic [QCOUNT_W-1:0] o_count_reg;
    logic [STATUS_W-1:0] o_status_reg;

    // Cell row control
    cell_cmd_t          chain_cmd;
    logic [IDX_W-1:0]   load_idx;
    logic [ID_BITS-1:0] load_val;
    logic [ID_BITS-1:0] head;

    logic               slot_free;
    logic               emit;
    logic               e_disp_valid;
    logic [ID_BITS-1:0] e_disp_id;
    logic [STATUS_W-1:0] e_status;
    logic [CNT_W-1:0]   cnt_dec;
    logic               drop;

    frqs_chain #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ID_BITS     (ID_BITS)
    ) u_chain (
        .clk      (clk),
        .cmd      (chain_cmd),
        .load_idx (load_idx),
        .load_val (load_val),
        .head     (head)
    );

    assign slot_free = !rsp_valid_reg || rsp.ready;
    assign cnt_dec   = cnt_reg - CNT_W'(1);
    assign drop      = !found_reg && (head == id_reg);
    assign req.ready = (state_reg == S_IDLE);

    // Sequencer and queue operations
    always_comb
    begin
        state_next      = state_reg;
        func_next       = func_reg;
        id_next         = id_reg;
        cnt_next        = cnt_reg;
        scan_next       = scan_reg;
        found_next      = found_reg;
        run_valid_next  = run_valid_reg;
        run_id_next     = run_id_reg;
        chain_cmd.shift = 1'b0;
        chain_cmd.load  = 1'b0;
        load_idx        = '0;
        load_val        = head;
        emit            = 1'b0;
        e_disp_valid    = 1'b0;
        e_disp_id       = '0;
        e_status        = ST_OK;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    func_next  = req.func;
                    id_next    = ID_BITS'(req.thread_id);
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                if (func_reg == FN_TERM)
                begin
                    found_next = 1'b0;
                    scan_next  = cnt_reg;
                    state_next = (cnt_reg != '0) ? S_SCAN : S_RESOLVE;
                end
                else if (slot_free)
                begin
                    emit       = 1'b1;
                    state_next = S_IDLE;
                    case (func_reg)
                        FN_YIELD:
                        begin
                            if (run_valid_reg && cnt_reg != '0)
                            begin
                                // head leaves, running thread goes to the tail
                                e_disp_valid    = 1'b1;
                                e_disp_id       = head;
                                chain_cmd.shift = 1'b1;
                                chain_cmd.load  = 1'b1;
                                load_idx        = cnt_dec[IDX_W-1:0];
                                load_val        = run_id_reg;
                                run_id_next     = head;
                            end
                            else if (run_valid_reg)
                            begin
                                e_disp_valid = 1'b1;
                                e_disp_id    = run_id_reg;
                            end
                            else if (cnt_reg != '0)
                            begin
                                e_disp_valid    = 1'b1;
                                e_disp_id       = head;
                                chain_cmd.shift = 1'b1;
                                cnt_next        = cnt_dec;
                                run_valid_next  = 1'b1;
                                run_id_next     = head;
                            end
                            else
                            begin
                                e_status = ST_NONE;
                            end
                        end
                        FN_ADD:
                        begin
                            if (cnt_reg < CNT_W'(QUEUE_DEPTH))
                            begin
                                chain_cmd.load = 1'b1;
                                load_idx       = cnt_reg[IDX_W-1:0];
                                load_val       = id_reg;
                                cnt_next       = cnt_reg + CNT_W'(1);
                            end
                            else
                            begin
                                e_status = ST_FULL;
                            end
                        end
                        default:
                        begin
                            e_status = ST_OK;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                // One rotation step: head goes to the tail unless it is the first match
                chain_cmd.shift = 1'b1;
                if (drop)
                begin
                    cnt_next   = cnt_dec;
                    found_next = 1'b1;
                end
                else
                begin
                    chain_cmd.load = 1'b1;
                    load_idx       = cnt_dec[IDX_W-1:0];
                    load_val       = head;
                end
                scan_next = scan_reg - CNT_W'(1);
                if (scan_reg == CNT_W'(1))
                begin
                    state_next = S_RESOLVE;
                end
            end

            S_RESOLVE:
            begin
                if (slot_free)
                begin
                    emit       = 1'b1;
                    state_next = S_IDLE;
                    if (run_valid_reg && run_id_reg == id_reg)
                    begin
                        if (cnt_reg != '0)
                        begin
                            e_disp_valid    = 1'b1;
                            e_disp_id       = head;
                            chain_cmd.shift = 1'b1;
                            cnt_next        = cnt_dec;
                            run_id_next     = head;
                        end
                        else
                        begin
                            run_valid_next = 1'b0;
                            run_id_next    = '0;
                            e_status       = ST_NONE;
                        end
                    end
                    else if (!found_reg)
                    begin
                        e_status = ST_NOTFOUND;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            found_reg     <= 1'b0;
            run_valid_reg <= 1'b0;
            run_id_reg    <= '0;
            scan_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            found_reg     <= found_next;
            run_valid_reg <= run_valid_next;
            run_id_reg    <= run_id_next;
            scan_reg      <= scan_next;
            if (emit)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Request and result payload
    always_ff @(posedge clk)
    begin
        func_reg <= func_next;
        id_reg   <= id_next;
        if (emit)
        begin
            o_disp_valid_reg <= e_disp_valid;
            o_disp_id_reg    <= ID_W'(e_disp_id);
            o_run_valid_reg  <= run_valid_next;
            o_run_id_reg     <= run_valid_next ? ID_W'(run_id_next) : '0;
            o_count_reg      <= QCOUNT_W'(cnt_next);
            o_status_reg     <= e_status;
        end
    end

    assign rsp.valid          = rsp_valid_reg;
    assign rsp.dispatch_valid = o_disp_valid_reg;
    assign rsp.dispatch_id    = o_disp_id_reg;
    assign rsp.running_valid  = o_run_valid_reg;
    assign rsp.running_id     = o_run_id_reg;
    assign rsp.queue_count    = o_count_reg;
    assign rsp.status         = o_status_reg;

endmodule

`default_nettype wire

// File: hdl/frqs_cell.sv
`default_nettype none

module frqs_cell #(
    parameter int ID_BITS = frqs_pkg::ID_BITS_DEF
) (
    input  wire logic               clk,
    input  wire frqs_pkg::cell_cmd_t cmd,
    input  wire logic [ID_BITS-1:0] load_val,
    input  wire logic [ID_BITS-1:0] right_val,
    output logic      [ID_BITS-1:0] value
);
    import frqs_pkg::*;

    logic [ID_BITS-1:0] data_reg;
    logic [ID_BITS-1:0] data_next;

    // Load beats shift; otherwise hold
    always_comb
    begin
        data_next = data_reg;
        if (cmd.load)
        begin
            data_next = load_val;
        end
        else if (cmd.shift)
        begin
            data_next = right_val;
        end
    end

    // Entry storage, contents meaningless until written
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign value = data_reg;

endmodule

`default_nettype wire

// File: hdl/frqs_chain.sv
`default_nettype none

module frqs_chain #(
    parameter int QUEUE_DEPTH = frqs_pkg::QUEUE_DEPTH_DEF,
    parameter int ID_BITS     = frqs_pkg::ID_BITS_DEF,
    localparam int IDX_W      = $clog2(QUEUE_DEPTH)
) (
    input  wire logic               clk,
    input  wire frqs_pkg::cell_cmd_t cmd,
    input  wire logic [IDX_W-1:0]   load_idx,
    input  wire logic [ID_BITS-1:0] load_val,
    output logic      [ID_BITS-1:0] head
);
    import frqs_pkg::*;

    logic [ID_BITS-1:0] cell_val [QUEUE_DEPTH];

    // Row of cells, head at index 0, entries move toward the head on shift
    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        cell_cmd_t          cell_cmd;
        logic [ID_BITS-1:0] right_val;

        assign cell_cmd.shift = cmd.shift;
        assign cell_cmd.load  = cmd.load && (load_idx == IDX_W'(i));

        if (i == QUEUE_DEPTH - 1)
        begin : g_last
            assign right_val = cell_val[i];
        end
        else
        begin : g_mid
            assign right_val = cell_val[i+1];
        end

        frqs_cell #(
            .ID_BITS (ID_BITS)
        ) u_cell (
            .clk       (clk),
            .cmd       (cell_cmd),
            .load_val  (load_val),
            .right_val (right_val),
            .value     (cell_val[i])
        );
    end

    assign head = cell_val[0];

endmodule

`default_nettype wire

// File: hdl/frqs_check.sv
`default_nettype none

module frqs_check (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          rsp_valid,
    input wire logic                          rsp_ready,
    input wire logic                          dispatch_valid,
    input wire logic [frqs_pkg::ID_W-1:0]     dispatch_id,
    input wire logic                          running_valid,
    input wire logic [frqs_pkg::ID_W-1:0]     running_id,
    input wire logic [frqs_pkg::STATUS_W-1:0] status
);
    import frqs_pkg::*;

    // A pending result transaction holds until taken
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(dispatch_id) && $stable(status))
        else $error("result transaction dropped or changed while stalled");

    // A dispatched thread becomes the running thread
    a_disp_runs: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && dispatch_valid |-> running_valid && running_id == dispatch_id)
        else $error("dispatched thread is not the running thread");

    // No running thread reports id zero
    a_idle_id: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !running_valid |-> running_id == '0)
        else $error("running id set with no running thread");

    // Nothing to run means no dispatch and nothing running
    a_none: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == ST_NONE |-> !dispatch_valid && !running_valid)
        else $error("nothing-to-run status with a thread dispatched or running");

endmodule

bind fifo_ready_queue_scheduler_core frqs_check u_frqs_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .dispatch_valid (rsp.dispatch_valid),
    .dispatch_id    (rsp.dispatch_id),
    .running_valid  (rsp.running_valid),
    .running_id     (rsp.running_id),
    .status         (rsp.status)
);

`default_nettype wire
